>>> src/vna_pkg.sv
// Shared types and constants for the vertex normal accumulator.
// No dependencies; used by src/vertex_normal_accumulator.sv and the testbench files.
`timescale 1ns / 1ps

package vna_pkg;

    localparam int MAX_VERTICES_DEF = 1024;

    localparam int IDX_W   = 10;
    localparam int COORD_W = 18;
    localparam int ACC_W   = 48;
    localparam int NORM_W  = 16;
    localparam int EDGE_W  = COORD_W + 1;
    localparam int CROSS_W = 2 * EDGE_W + 1;
    localparam int MUL_W   = 25;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int SQ_W    = 52;
    localparam int DIV_W   = 40;

    localparam int S_TDATA_W = 88;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 56;
    localparam int M_TUSER_W = 1;

    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_TRI   = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;
    localparam logic [1:0] REQ_NONE  = 2'd3;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_VRD,
        ST_CROSS,
        ST_ARD,
        ST_AWR,
        ST_MAG,
        ST_SHIFT,
        ST_SQ,
        ST_SQRT,
        ST_DIVI,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage

>>> src/vertex_normal_accumulator.sv
// Area-weighted vertex normal accumulator: vertex store, normal accumulators,
// cross product, and normalization with a shared multiplier. Depends on vna_pkg.
`timescale 1ns / 1ps

// The block takes one item at a time on the slave stream. tuser carries the
// request kind: write a vertex, accumulate a triangle, or read a normal.
// Every item gives exactly one result item on the master stream; tuser
// there is high when the result carries a normal and low for a plain
// acknowledgment.
// A vertex write or an unused selector passes from the execute state
// straight to its result. A triangle takes three vertex store reads, six
// products through one shared multiplier, then a read and a write-back of
// the accumulator memory for each corner. A normal read of a zero vector
// goes straight to its result; otherwise it runs the bit-serial shift
// to 24 bits, the 26-step integer square root and three 15-step divisions.
// The next item can be taken in the cycle after the result is loaded.
// After reset the accumulator memory is swept to zero, one entry a cycle,
// and s_axis_tready stays low during the sweep.
// The result sits in an output register; when the receiver stalls, the
// block finishes its current item and holds it until the result register
// frees, then takes the next item.
module vertex_normal_accumulator #(
    parameter int MAX_VERTICES = vna_pkg::MAX_VERTICES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata: vertex_index[9:0], corner_b[19:10], corner_c[29:20],
    // pos_x[47:30], pos_y[65:48], pos_z[83:66], zero fill[87:84]
    input  logic [vna_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // tuser: req_type[1:0]
    input  logic [vna_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // tdata: norm_x[15:0], norm_y[31:16], norm_z[47:32], zero_length[48],
    // zero fill[55:49]
    output logic [vna_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // tuser: is_normal[0]
    output logic [vna_pkg::M_TUSER_W-1:0]  m_axis_tuser
);

    localparam int AW      = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int VW      = 3 * vna_pkg::COORD_W;
    localparam int AccRowW = 3 * vna_pkg::ACC_W;
    localparam int CmpW    = 18;

    // Memories.
    logic [VW-1:0]      vmem [MAX_VERTICES];
    logic [AccRowW-1:0] amem [MAX_VERTICES];

    vna_pkg::t_state r_state, n_state;

    logic [AW-1:0] r_clr;
    logic [1:0]    r_kind;
    logic [vna_pkg::IDX_W-1:0] r_ia, r_ib, r_ic;
    logic [VW-1:0] r_pos;
    logic [3:0]    r_cnt;
    logic [1:0]    r_k;

    logic [VW-1:0]      r_vrd, r_va;
    logic [AccRowW-1:0] r_ard;

    logic signed [vna_pkg::EDGE_W-1:0]  r_e1 [3];
    logic signed [vna_pkg::EDGE_W-1:0]  r_e2 [3];
    logic signed [vna_pkg::CROSS_W-1:0] r_n  [3];
    logic signed [vna_pkg::PROD_W-1:0]  r_prod;

    logic [vna_pkg::ACC_W-1:0] r_mag [3];
    logic [vna_pkg::ACC_W-1:0] r_m;
    logic [2:0]                r_neg;
    logic [vna_pkg::SQ_W-1:0]  r_sum, r_srem, r_sres, r_bit;
    logic [vna_pkg::DIV_W-1:0] r_drem, r_dsh;
    logic [14:0]               r_q;

    logic signed [vna_pkg::NORM_W-1:0] r_res [3];
    logic r_zl;

    logic                           r_mvalid;
    logic [vna_pkg::M_TDATA_W-1:0]  r_mdata;
    logic                           r_muser;

    // Memory port controls.
    logic               v_we, a_we;
    logic [AW-1:0]      v_raddr, a_raddr, a_waddr;
    logic [AccRowW-1:0] a_wdata;

    logic signed [vna_pkg::MUL_W-1:0] mul_a, mul_b;

    logic [vna_pkg::ACC_W-1:0]  mag_c [3];
    logic [vna_pkg::ACC_W-1:0]  m_c;
    logic [AW-1:0]              corner_addr;
    logic                       a_ok, b_ok, c_ok;
    logic [vna_pkg::SQ_W-1:0]   sq_try;
    logic                       sq_ge;
    logic                       d_ge;
    logic [14:0]                n_q;
    logic [1:0]                 n_idx;
    logic signed [vna_pkg::EDGE_W-1:0] vrd_c [3];
    logic signed [vna_pkg::EDGE_W-1:0] va_c  [3];

    assign a_ok = CmpW'(r_ia) < CmpW'(MAX_VERTICES);
    assign b_ok = CmpW'(r_ib) < CmpW'(MAX_VERTICES);
    assign c_ok = CmpW'(r_ic) < CmpW'(MAX_VERTICES);

    always_comb begin
        case (r_k)
            2'd0:    corner_addr = AW'(r_ia);
            2'd1:    corner_addr = AW'(r_ib);
            default: corner_addr = AW'(r_ic);
        endcase
    end

    // Magnitudes of the accumulator components just read.
    always_comb begin
        logic signed [vna_pkg::ACC_W-1:0] acc;
        m_c = '0;
        for (int i = 0; i < 3; i++) begin
            acc      = $signed(r_ard[i*vna_pkg::ACC_W +: vna_pkg::ACC_W]);
            mag_c[i] = acc[vna_pkg::ACC_W-1] ? vna_pkg::ACC_W'(-acc) : vna_pkg::ACC_W'(acc);
            if (mag_c[i] > m_c) begin
                m_c = mag_c[i];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            vrd_c[i] = vna_pkg::EDGE_W'($signed(r_vrd[i*vna_pkg::COORD_W +: vna_pkg::COORD_W]));
            va_c[i]  = vna_pkg::EDGE_W'($signed(r_va[i*vna_pkg::COORD_W +: vna_pkg::COORD_W]));
        end
    end

    assign sq_try = r_sres + r_bit;
    assign sq_ge  = r_srem >= sq_try;
    assign d_ge   = r_drem >= r_dsh;
    assign n_q    = {r_q[13:0], d_ge};
    // Cross product component that the arriving product belongs to.
    assign n_idx  = 2'((r_cnt[2:0] - 3'd1) >> 1);

    // Next state, memory controls and multiplier operands.
    always_comb begin
        logic signed [vna_pkg::ACC_W:0] diff;
        diff    = '0;
        n_state = r_state;
        v_we    = 1'b0;
        a_we    = 1'b0;
        v_raddr = AW'(r_ia);
        a_raddr = AW'(r_ia);
        a_waddr = r_clr;
        a_wdata = '0;
        mul_a   = '0;
        mul_b   = '0;
        unique case (r_state)
            vna_pkg::ST_CLEAR: begin
                a_we = 1'b1;
                if (r_clr == AW'(MAX_VERTICES - 1)) begin
                    n_state = vna_pkg::ST_IDLE;
                end
            end
            vna_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = vna_pkg::ST_EXEC;
                end
            end
            vna_pkg::ST_EXEC: begin
                unique case (r_kind)
                    vna_pkg::REQ_WRITE: begin
                        if (a_ok) begin
                            v_we    = 1'b1;
                            a_we    = 1'b1;
                            a_waddr = AW'(r_ia);
                        end
                        n_state = vna_pkg::ST_DONE;
                    end
                    vna_pkg::REQ_TRI: begin
                        n_state = (a_ok && b_ok && c_ok) ? vna_pkg::ST_VRD : vna_pkg::ST_DONE;
                    end
                    vna_pkg::REQ_READ: n_state = vna_pkg::ST_MAG;
                    default:           n_state = vna_pkg::ST_DONE;
                endcase
            end
            vna_pkg::ST_VRD: begin
                case (r_cnt)
                    4'd0:    v_raddr = AW'(r_ia);
                    4'd1:    v_raddr = AW'(r_ib);
                    default: v_raddr = AW'(r_ic);
                endcase
                if (r_cnt == 4'd3) begin
                    n_state = vna_pkg::ST_CROSS;
                end
            end
            vna_pkg::ST_CROSS: begin
                case (r_cnt)
                    4'd0: begin mul_a = vna_pkg::MUL_W'(r_e1[1]); mul_b = vna_pkg::MUL_W'(r_e2[2]); end
                    4'd1: begin mul_a = vna_pkg::MUL_W'(r_e1[2]); mul_b = vna_pkg::MUL_W'(r_e2[1]); end
                    4'd2: begin mul_a = vna_pkg::MUL_W'(r_e1[2]); mul_b = vna_pkg::MUL_W'(r_e2[0]); end
                    4'd3: begin mul_a = vna_pkg::MUL_W'(r_e1[0]); mul_b = vna_pkg::MUL_W'(r_e2[2]); end
                    4'd4: begin mul_a = vna_pkg::MUL_W'(r_e1[0]); mul_b = vna_pkg::MUL_W'(r_e2[1]); end
                    4'd5: begin mul_a = vna_pkg::MUL_W'(r_e1[1]); mul_b = vna_pkg::MUL_W'(r_e2[0]); end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
                if (r_cnt == 4'd6) begin
                    n_state = vna_pkg::ST_ARD;
                end
            end
            vna_pkg::ST_ARD: begin
                a_raddr = corner_addr;
                n_state = vna_pkg::ST_AWR;
            end
            vna_pkg::ST_AWR: begin
                a_we    = 1'b1;
                a_waddr = corner_addr;
                for (int i = 0; i < 3; i++) begin
                    diff = (vna_pkg::ACC_W+1)'($signed(r_ard[i*vna_pkg::ACC_W +: vna_pkg::ACC_W]))
                         - (vna_pkg::ACC_W+1)'(r_n[i]);
                    if (diff[vna_pkg::ACC_W] != diff[vna_pkg::ACC_W-1]) begin
                        // Saturate to the 48-bit signed range.
                        a_wdata[i*vna_pkg::ACC_W +: vna_pkg::ACC_W] =
                            {diff[vna_pkg::ACC_W], {(vna_pkg::ACC_W-1){~diff[vna_pkg::ACC_W]}}};
                    end else begin
                        a_wdata[i*vna_pkg::ACC_W +: vna_pkg::ACC_W] = diff[vna_pkg::ACC_W-1:0];
                    end
                end
                n_state = (r_k == 2'd2) ? vna_pkg::ST_DONE : vna_pkg::ST_ARD;
            end
            vna_pkg::ST_MAG: begin
                n_state = (!a_ok || m_c == '0) ? vna_pkg::ST_DONE : vna_pkg::ST_SHIFT;
            end
            vna_pkg::ST_SHIFT: begin
                if (r_m < (vna_pkg::ACC_W'(1) << 24)) begin
                    n_state = vna_pkg::ST_SQ;
                end
            end
            vna_pkg::ST_SQ: begin
                if (r_cnt < 4'd3) begin
                    mul_a = vna_pkg::MUL_W'(r_mag[r_cnt[1:0]][23:0]);
                    mul_b = vna_pkg::MUL_W'(r_mag[r_cnt[1:0]][23:0]);
                end
                if (r_cnt == 4'd3) begin
                    n_state = vna_pkg::ST_SQRT;
                end
            end
            vna_pkg::ST_SQRT: begin
                if (r_bit == vna_pkg::SQ_W'(1)) begin
                    n_state = vna_pkg::ST_DIVI;
                end
            end
            vna_pkg::ST_DIVI: n_state = vna_pkg::ST_DIV;
            vna_pkg::ST_DIV: begin
                if (r_cnt == 4'd14) begin
                    n_state = (r_k == 2'd2) ? vna_pkg::ST_DONE : vna_pkg::ST_DIVI;
                end
            end
            vna_pkg::ST_DONE: begin
                if (!r_mvalid || m_axis_tready) begin
                    n_state = vna_pkg::ST_IDLE;
                end
            end
            default: n_state = vna_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vna_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Memories: one write and one registered read each per cycle.
    always_ff @(posedge i_clk) begin
        if (v_we) begin
            vmem[AW'(r_ia)] <= r_pos;
        end
        r_vrd <= vmem[v_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (a_we) begin
            amem[a_waddr] <= a_wdata;
        end
        r_ard <= amem[a_raddr];
    end

    // Shared multiplier, registered.
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (r_state == vna_pkg::ST_CLEAR) begin
            r_clr <= r_clr + AW'(1);
        end
        case (r_state)
            vna_pkg::ST_IDLE: begin
                r_kind <= s_axis_tuser;
                r_ia   <= s_axis_tdata[9:0];
                r_ib   <= s_axis_tdata[19:10];
                r_ic   <= s_axis_tdata[29:20];
                r_pos  <= s_axis_tdata[83:30];
                r_cnt  <= '0;
                r_k    <= '0;
                r_zl   <= 1'b0;
                for (int i = 0; i < 3; i++) begin
                    r_res[i] <= '0;
                    r_n[i]   <= '0;
                end
            end
            vna_pkg::ST_VRD: begin
                r_cnt <= (r_cnt == 4'd3) ? 4'd0 : r_cnt + 4'd1;
                if (r_cnt == 4'd1) begin
                    r_va <= r_vrd;
                end
                for (int i = 0; i < 3; i++) begin
                    if (r_cnt == 4'd2) r_e1[i] <= vrd_c[i] - va_c[i];
                    if (r_cnt == 4'd3) r_e2[i] <= vrd_c[i] - va_c[i];
                end
            end
            vna_pkg::ST_CROSS: begin
                r_cnt <= r_cnt + 4'd1;
                // The product of step j arrives in the next cycle.
                if (r_cnt != 4'd0) begin
                    if (r_cnt[0]) begin
                        r_n[n_idx] <= vna_pkg::CROSS_W'(r_prod);
                    end else begin
                        r_n[n_idx] <= r_n[n_idx] - vna_pkg::CROSS_W'(r_prod);
                    end
                end
            end
            vna_pkg::ST_AWR: begin
                r_k <= r_k + 2'd1;
            end
            vna_pkg::ST_MAG: begin
                for (int i = 0; i < 3; i++) begin
                    r_mag[i] <= mag_c[i];
                    r_neg[i] <= r_ard[(i+1)*vna_pkg::ACC_W - 1];
                end
                r_m  <= m_c;
                r_zl <= !a_ok || m_c == '0;
            end
            vna_pkg::ST_SHIFT: begin
                r_sum <= '0;
                if (r_m >= (vna_pkg::ACC_W'(1) << 24)) begin
                    r_m <= r_m >> 1;
                    for (int i = 0; i < 3; i++) begin
                        r_mag[i] <= r_mag[i] >> 1;
                    end
                end
            end
            vna_pkg::ST_SQ: begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt != 4'd0) begin
                    r_sum <= r_sum + vna_pkg::SQ_W'(r_prod[47:0]);
                end
                if (r_cnt == 4'd3) begin
                    r_srem <= r_sum + vna_pkg::SQ_W'(r_prod[47:0]);
                    r_sres <= '0;
                    r_bit  <= vna_pkg::SQ_W'(1) << 50;
                    r_k    <= '0;
                end
            end
            vna_pkg::ST_SQRT: begin
                if (sq_ge) begin
                    r_srem <= r_srem - sq_try;
                    r_sres <= (r_sres >> 1) + r_bit;
                end else begin
                    r_sres <= r_sres >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            vna_pkg::ST_DIVI: begin
                // Rounded quotient: (mag * 16384 + len / 2) / len.
                r_drem <= (vna_pkg::DIV_W'(r_mag[r_k][23:0]) << 14)
                        + vna_pkg::DIV_W'(r_sres[24:1]);
                r_dsh  <= vna_pkg::DIV_W'(r_sres[24:0]) << 14;
                r_q    <= '0;
                r_cnt  <= '0;
            end
            vna_pkg::ST_DIV: begin
                if (d_ge) begin
                    r_drem <= r_drem - r_dsh;
                end
                r_dsh <= r_dsh >> 1;
                r_q   <= n_q;
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd14) begin
                    r_res[r_k] <= r_neg[r_k] ? -vna_pkg::NORM_W'(n_q) : vna_pkg::NORM_W'(n_q);
                    r_k        <= r_k + 2'd1;
                end
            end
            default: begin
            end
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvalid <= 1'b0;
        end else if (r_state == vna_pkg::ST_DONE && (!r_mvalid || m_axis_tready)) begin
            r_mvalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_mvalid <= 1'b0;
        end
        if (r_state == vna_pkg::ST_DONE && (!r_mvalid || m_axis_tready)) begin
            r_mdata <= {7'd0, r_zl, r_res[2], r_res[1], r_res[0]};
            r_muser <= (r_kind == vna_pkg::REQ_READ);
        end
    end

    assign s_axis_tready = (r_state == vna_pkg::ST_IDLE);
    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_mdata;
    assign m_axis_tuser  = r_muser;

`ifndef NO_ASSERTIONS
    // No item is taken while the accumulator sweep runs.
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == vna_pkg::ST_CLEAR |-> !s_axis_tready)
        else $error("item accepted during accumulator sweep");

    // A taken result that is not replaced leaves the output empty.
    a_out_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && r_state != vna_pkg::ST_DONE) |=> !m_axis_tvalid)
        else $error("result repeated after acceptance");

    // A unit-normal component never exceeds one in Q1.14.
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == vna_pkg::ST_DIV && r_cnt == 4'd14) |-> n_q <= 15'd16384)
        else $error("normalized component out of range");
`endif

endmodule

>>> tb/vna_checker.sv
// Checker for the vertex normal accumulator: watches both streams, predicts every result
// and compares it field by field. Depends on vna_pkg.
`timescale 1ns / 1ps

module vna_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [vna_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    input  logic [vna_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [vna_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input  logic [vna_pkg::M_TUSER_W-1:0]  m_axis_tuser,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_normals,
    output int                             o_zero_reads
);
    import vna_pkg::*;

    localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint ACC_LO = -ACC_HI - 1;

    typedef struct packed {
        logic        is_normal;
        logic [15:0] nx;
        logic [15:0] ny;
        logic [15:0] nz;
        logic        zero_len;
    } t_result;

    t_result result_q[$];
    longint  pos_mem [MAX_VERTICES_DEF][3];
    longint  acc_mem [MAX_VERTICES_DEF][3];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_normals    = 0;
        o_zero_reads = 0;
    end

    function automatic longint clamp48(input longint v);
        if (v > ACC_HI) return ACC_HI;
        if (v < ACC_LO) return ACC_LO;
        return v;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b   = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Scales an accumulated normal to unit length in Q1.14.
    function automatic t_result unit_normal(input int idx);
        t_result         r;
        longint unsigned mag [3];
        longint unsigned peak, sum, len, q;
        longint          sv;
        int              sh;
        r           = '0;
        r.is_normal = 1'b1;
        peak        = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = (acc_mem[idx][i] < 0) ? longint'(-acc_mem[idx][i]) : acc_mem[idx][i];
            if (mag[i] > peak) peak = mag[i];
        end
        if (peak == 0) begin
            r.zero_len = 1'b1;
            return r;
        end
        sh = 0;
        while ((peak >> sh) >= (64'd1 << 24)) sh++;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = mag[i] >> sh;
            sum    = sum + mag[i] * mag[i];
        end
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            q  = (mag[i] * 16384 + len / 2) / len;
            sv = (acc_mem[idx][i] < 0) ? -longint'(q) : longint'(q);
            if (i == 0) r.nx = sv[15:0];
            else if (i == 1) r.ny = sv[15:0];
            else r.nz = sv[15:0];
        end
        return r;
    endfunction

    // Applies one request to the mirrored vertex and accumulator state.
    function automatic t_result apply_request(input logic [1:0] kind,
                                              input logic [S_TDATA_W-1:0] d);
        t_result r;
        int      ia, ib, ic;
        int      corner [3];
        longint  e1 [3];
        longint  e2 [3];
        longint  n [3];
        r  = '0;
        ia = d[9:0];
        ib = d[19:10];
        ic = d[29:20];
        case (kind)
            REQ_WRITE: begin
                pos_mem[ia][0] = longint'($signed(d[47:30]));
                pos_mem[ia][1] = longint'($signed(d[65:48]));
                pos_mem[ia][2] = longint'($signed(d[83:66]));
                for (int i = 0; i < 3; i++) acc_mem[ia][i] = 0;
            end
            REQ_TRI: begin
                for (int i = 0; i < 3; i++) begin
                    e1[i] = pos_mem[ib][i] - pos_mem[ia][i];
                    e2[i] = pos_mem[ic][i] - pos_mem[ia][i];
                end
                n[0] = e1[1] * e2[2] - e1[2] * e2[1];
                n[1] = e1[2] * e2[0] - e1[0] * e2[2];
                n[2] = e1[0] * e2[1] - e1[1] * e2[0];
                corner[0] = ia;
                corner[1] = ib;
                corner[2] = ic;
                // Corners are updated in order, so a repeated corner sees its own update.
                for (int k = 0; k < 3; k++)
                    for (int i = 0; i < 3; i++)
                        acc_mem[corner[k]][i] = clamp48(acc_mem[corner[k]][i] - n[i]);
            end
            REQ_READ: r = unit_normal(ia);
            default: r = '0;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            result_q.delete();
            for (int v = 0; v < MAX_VERTICES_DEF; v++)
                for (int i = 0; i < 3; i++) acc_mem[v][i] = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.is_normal = m_axis_tuser[0];
                got.nx        = m_axis_tdata[15:0];
                got.ny        = m_axis_tdata[31:16];
                got.nz        = m_axis_tdata[47:32];
                got.zero_len  = m_axis_tdata[48];
                if (got.is_normal) o_normals++;
                if (got.is_normal && got.zero_len) o_zero_reads++;
                if (result_q.size() == 0) begin
                    $display("%0t: result item with none expected: %h", $time, got);
                    o_fail_count++;
                end else begin
                    want = result_q.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch expected norm=%0b x=%0d y=%0d z=%0d zero=%0b",
                                 $time, want.is_normal, $signed(want.nx), $signed(want.ny),
                                 $signed(want.nz), want.zero_len);
                        $display("%0t:          actual   norm=%0b x=%0d y=%0d z=%0d zero=%0b",
                                 $time, got.is_normal, $signed(got.nx), $signed(got.ny),
                                 $signed(got.nz), got.zero_len);
                        o_fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                result_q.push_back(apply_request(s_axis_tuser, s_axis_tdata));
        end
        o_pending = result_q.size();
    end

endmodule

>>> tb/testbench.sv
// Top of the vertex normal accumulator testbench: clock, reset, stimulus and verdict.
// Depends on vna_pkg, vertex_normal_accumulator and vna_checker.
`timescale 1ns / 1ps

module testbench;
    import vna_pkg::*;

    localparam int LIMIT = 3_000_000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [S_TUSER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;

    int fail_count, pending, normals, zero_reads;
    int send_idle = 0;
    int recv_stall = 0;
    int cycles = 0;
    int sent = 0;
    int pool [16];

    vertex_normal_accumulator u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready),
        .s_axis_tdata(s_tdata), .s_axis_tuser(s_tuser),
        .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready),
        .m_axis_tdata(m_tdata), .m_axis_tuser(m_tuser)
    );

    vna_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready),
        .s_axis_tdata(s_tdata), .s_axis_tuser(s_tuser),
        .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready),
        .m_axis_tdata(m_tdata), .m_axis_tuser(m_tuser),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_normals(normals), .o_zero_reads(zero_reads)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // The receiver stalls at random with the probability of the current phase.
    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(99) >= recv_stall);
        cycles   <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("testbench failed");
            $finish;
        end
    end

    // Phases rotate through no idling, a mostly idle sender, a mostly stalled
    // receiver, and light idling on both sides.
    function automatic void set_phase(input int p);
        case (p % 4)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 78; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 78; end
            default: begin send_idle = 11; recv_stall = 11; end
        endcase
    endfunction

    function automatic logic [S_TDATA_W-1:0] pack(input int a, input int b, input int c,
                                                  input int x, input int y, input int z);
        logic [S_TDATA_W-1:0] d;
        d        = '0;
        d[9:0]   = a[9:0];
        d[19:10] = b[9:0];
        d[29:20] = c[9:0];
        d[47:30] = x[17:0];
        d[65:48] = y[17:0];
        d[83:66] = z[17:0];
        return d;
    endfunction

    function automatic int rand_coord();
        case ($urandom_range(7))
            0: return -131072;
            1: return 131071;
            2: return $urandom_range(0, 512) - 256;
            default: return $urandom_range(0, 262143) - 131072;
        endcase
    endfunction

    // Presents one item and returns at the edge where it is taken. valid is
    // only lowered when an idle gap follows, so it gets one update per edge.
    task automatic put_item(input logic [1:0] kind, input logic [S_TDATA_W-1:0] d);
        if ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= d;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sent++;
    endtask

    task automatic write_vertex(input int idx, input int x, input int y, input int z);
        put_item(REQ_WRITE, pack(idx, $urandom_range(1023), $urandom_range(1023), x, y, z));
    endtask

    task automatic triangle(input int a, input int b, input int c);
        put_item(REQ_TRI, pack(a, b, c, rand_coord(), rand_coord(), rand_coord()));
    endtask

    task automatic read_normal(input int idx);
        put_item(REQ_READ, pack(idx, $urandom_range(1023), $urandom_range(1023),
                                rand_coord(), rand_coord(), rand_coord()));
    endtask

    task automatic refill_pool();
        for (int i = 0; i < 16; i++) begin
            pool[i] = (i < 4) ? $urandom_range(1023) : $urandom_range(63);
            write_vertex(pool[i], rand_coord(), rand_coord(), rand_coord());
        end
    endtask

    initial begin
        int pick, a, b, c;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed items: extreme coordinates, a zero accumulator, repeated
        // corners, an unused selector, a never-written read and a cancelling pair.
        write_vertex(0, 0, 0, 0);
        write_vertex(1, 131071, 0, 0);
        write_vertex(2, 0, 131071, 0);
        write_vertex(1023, -131072, -131072, -131072);
        read_normal(0);
        triangle(0, 1, 2);
        read_normal(0);
        read_normal(1);
        read_normal(2);
        triangle(0, 0, 1);
        triangle(1023, 1, 2);
        read_normal(1023);
        read_normal(500);
        put_item(REQ_NONE, '1);
        triangle(2, 1, 0);
        read_normal(0);
        write_vertex(1, 131071, 131071, -131072);
        read_normal(1);
        triangle(0, 1, 1023);
        read_normal(1023);

        // General random traffic over a small working set of written vertices.
        for (int i = 0; i < 800; i++) begin
            if (i % 100 == 0) set_phase(i / 100);
            if (i % 300 == 0) refill_pool();
            pick = $urandom_range(99);
            a = pool[$urandom_range(15)];
            b = ($urandom_range(9) == 0) ? a : pool[$urandom_range(15)];
            c = ($urandom_range(9) == 0) ? b : pool[$urandom_range(15)];
            if (pick < 15) begin
                if ($urandom_range(3) == 0) a = $urandom_range(1023);
                write_vertex(a, rand_coord(), rand_coord(), rand_coord());
            end else if (pick < 60) begin
                triangle(a, b, c);
            end else if (pick < 95) begin
                read_normal(($urandom_range(4) == 0) ? $urandom_range(1023) : a);
            end else begin
                put_item(REQ_NONE, {4'b0, 84'({$urandom(), $urandom(), $urandom()})});
            end
        end

        // A long run of one large cross product grows one accumulator
        // component far past 24 bits; the reversed triangle then walks it back.
        write_vertex(1000, 0, -131072, 0);
        write_vertex(1001, 0, 131071, -131071);
        write_vertex(1002, 0, 131071, 131071);
        for (int i = 0; i < 1080; i++) begin
            if (i % 270 == 0) set_phase(i / 270);
            if (i % 100 == 99) read_normal(1000 + $urandom_range(2));
            else if (i < 900) triangle(1000, 1001, 1002);
            else triangle(1000, 1002, 1001);
        end
        read_normal(1000);

        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);

        $display("Sent %0d items: writes, triangles with repeated corners and a long run,",
                 sent);
        $display("%0d normal reads (%0d of zero length) and unused selector items.",
                 normals, zero_reads);
        if (fail_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

>>> sim.f
src/vna_pkg.sv
src/vertex_normal_accumulator.sv
tb/vna_checker.sv
tb/testbench.sv
